FILE: hw/rtl/bounded_deque_table_defines.svh
// assertion macros shared by the rtl
`ifndef BOUNDED_DEQUE_TABLE_DEFINES_SVH
`define BOUNDED_DEQUE_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define BDT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define BDT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define BDT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BDT_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/bdt_pkg.sv
package bdt_pkg;

  localparam int ACT_W  = 3;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_HEAD = 3'd0,
    ACT_INS_TAIL = 3'd1,
    ACT_REM_HEAD = 3'd2,
    ACT_REM_TAIL = 3'd3,
    ACT_RD_HEAD  = 3'd4,
    ACT_RD_TAIL  = 3'd5,
    ACT_RD_INDEX = 3'd6
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // per-transaction info carried alongside the memory read
  typedef struct packed {
    logic             rd;
    status_t          status;
    logic [CNT_W-1:0] count;
  } meta_t;

endpackage

FILE: hw/rtl/bdt_if.sv
interface bdt_in_if;
  logic                       valid;
  logic                       ready;
  logic [bdt_pkg::ACT_W-1:0]  action;
  logic [bdt_pkg::POS_W-1:0]  position;
  logic [bdt_pkg::DATA_W-1:0] element_in;

  modport source (output valid, output action, output position, output element_in,
                  input ready);
  modport sink   (input valid, input action, input position, input element_in,
                  output ready);
endinterface

interface bdt_out_if;
  logic                       valid;
  logic                       ready;
  logic [bdt_pkg::DATA_W-1:0] element_out;
  logic [bdt_pkg::STAT_W-1:0] status;
  logic [bdt_pkg::CNT_W-1:0]  count;

  modport source (output valid, output element_out, output status, output count,
                  input ready);
  modport sink   (input valid, input element_out, input status, input count,
                  output ready);
endinterface

FILE: hw/rtl/bdt_mem.sv
module bdt_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: hw/rtl/bdt_ctrl.sv
module bdt_ctrl #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  logic [bdt_pkg::ACT_W-1:0]         action,
  input  logic [bdt_pkg::POS_W-1:0]         position,
  input  logic [bdt_pkg::DATA_W-1:0]        element_in,
  output logic                              we,
  output logic                              re,
  output logic [$clog2(CAPACITY)-1:0]       addr,
  output logic [ELEMENT_WIDTH-1:0]          wdata,
  output bdt_pkg::meta_t                    meta,
  output logic [$clog2(CAPACITY+1)-1:0]     fill
);
  import bdt_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  logic [PW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;

  action_t       act;
  logic          full, empty;
  logic [PW-1:0] off, slot, head_dec;
  logic [PW:0]   sum;
  logic [CW-1:0] cnt_m1;
  logic [XW-1:0] pos_x, cnt_x;
  logic [63:0]   wide_in;
  logic          rd_hit;
  status_t       status;

  assign act      = action_t'(action);
  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign cnt_m1   = count - CW'(1);
  assign pos_x    = XW'(position);
  assign cnt_x    = XW'(count);
  assign head_dec = (head == '0) ? PW'(CAPACITY - 1) : head - PW'(1);
  assign wide_in  = 64'(element_in);
  assign wdata    = wide_in[ELEMENT_WIDTH-1:0];
  assign fill     = count;

  // list offset of the accessed element; for a head removal, the offset of the new head
  always_comb begin
    case (act)
      ACT_INS_TAIL: off = count[PW-1:0];
      ACT_REM_HEAD: off = PW'(1);
      ACT_RD_TAIL:  off = cnt_m1[PW-1:0];
      ACT_RD_INDEX: off = pos_x[PW-1:0];
      default:      off = '0;
    endcase
  end

  // ring slot of list offset; offset is below capacity wherever the slot is accessed
  assign sum  = {1'b0, head} + {1'b0, off};
  assign slot = (sum >= (PW+1)'(CAPACITY)) ? PW'(sum - (PW+1)'(CAPACITY)) : sum[PW-1:0];

  always_comb begin
    we         = 1'b0;
    rd_hit     = 1'b0;
    status     = ST_OK;
    head_next  = head;
    count_next = count;
    addr       = slot;
    case (act)
      ACT_INS_HEAD: begin
        addr = head_dec;
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          head_next  = head_dec;
          we         = 1'b1;
          count_next = count + CW'(1);
        end
      end
      ACT_INS_TAIL: begin
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          we         = 1'b1;
          count_next = count + CW'(1);
        end
      end
      ACT_REM_HEAD: begin
        if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          head_next  = slot;
          count_next = cnt_m1;
        end
      end
      ACT_REM_TAIL: begin
        if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          count_next = cnt_m1;
        end
      end
      ACT_RD_HEAD: begin
        if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          rd_hit = 1'b1;
        end
      end
      ACT_RD_TAIL: begin
        if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          rd_hit = 1'b1;
        end
      end
      ACT_RD_INDEX: begin
        if (pos_x >= XW'(CAPACITY)) begin
          status = ST_RANGE;
        end else if (pos_x < cnt_x) begin
          rd_hit = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign re          = fire & rd_hit;
  assign meta.rd     = rd_hit;
  assign meta.status = status;
  assign meta.count  = CNT_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (fire) begin
      head  <= head_next;
      count <= count_next;
    end
  end

endmodule

FILE: hw/rtl/bdt_out.sv
module bdt_out #(
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  bdt_pkg::meta_t           meta,
  input  logic [ELEMENT_WIDTH-1:0] rdata,
  output logic                     take,
  bdt_out_if.source                rsp
);
  import bdt_pkg::*;

  logic             s1_valid;
  meta_t            s1_meta;
  logic             advance;
  logic             out_valid;
  logic [DATA_W-1:0] out_elem;
  logic [STAT_W-1:0] out_status;
  logic [CNT_W-1:0]  out_count;
  logic [63:0]       rd_wide;

  assign rd_wide = 64'(rdata);
  assign advance = s1_valid && (!out_valid || rsp.ready);
  assign take    = !s1_valid || advance;

  // stage 1 waits for the memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_meta <= meta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_elem   <= s1_meta.rd ? rd_wide[DATA_W-1:0] : '0;
      out_status <= s1_meta.status;
      out_count  <= s1_meta.count;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.element_out = out_elem;
  assign rsp.status      = out_status;
  assign rsp.count       = out_count;

endmodule

FILE: hw/rtl/bounded_deque_table.sv
// channel | dir | payload                              | role
// req     | in  | action, position, element_in         | one deque action
// rsp     | out | element_out, status, count           | one result per action
//
// one transaction per cycle sustained while rsp is not stalled; the result is held
// first in the synchronous memory read register, then in the output register
// each action makes at most one access to the one-port element memory
// reset clears head pointer, count and valid flags; memory contents are not cleared
// a stalled rsp holds the output register; req keeps flowing until stage 1 is blocked
`include "bounded_deque_table_defines.svh"

module bounded_deque_table #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  bdt_in_if.sink   req,
  bdt_out_if.source rsp
);
  import bdt_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                     fire;
  logic                     take;
  logic                     we;
  logic                     re;
  logic [PW-1:0]            addr;
  logic [ELEMENT_WIDTH-1:0] wdata;
  logic [ELEMENT_WIDTH-1:0] rdata;
  logic [CW-1:0]            fill;
  meta_t                    meta;
  logic                     is_ins;

  assign req.ready = take;
  assign fire      = req.valid && take;
  assign is_ins    = (req.action == ACT_INS_HEAD) || (req.action == ACT_INS_TAIL);

  bdt_ctrl #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .action     (req.action),
    .position   (req.position),
    .element_in (req.element_in),
    .we         (we),
    .re         (re),
    .addr       (addr),
    .wdata      (wdata),
    .meta       (meta),
    .fill       (fill)
  );

  bdt_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEMENT_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (we && fire),
    .re    (re),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  bdt_out #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_out (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .meta  (meta),
    .rdata (rdata),
    .take  (take),
    .rsp   (rsp)
  );

  `BDT_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= CW'(CAPACITY))
  `BDT_ASSERT_NXT(a_full_ins_holds, clk, rst, fire && is_ins && (fill == CW'(CAPACITY)), $stable(fill))
  `BDT_ASSERT_IMP(a_ovf_count, clk, rst, rsp.valid && (rsp.status == ST_OVERFLOW), rsp.count == CNT_W'(CAPACITY))
  `BDT_ASSERT_IMP(a_unf_zero, clk, rst, rsp.valid && (rsp.status == ST_UNDERFLOW), rsp.element_out == '0)

endmodule

FILE: test/tb_top.sv
module tb_top;
  import bdt_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int HOLD_CYCLES = 160;
  localparam int DRAIN_WAIT  = 8;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] element;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } deque_result_t;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] elem;
    int                reps;
    bit                typed;
    deque_result_t     want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bdt_in_if  req_if ();
  bdt_out_if rsp_if ();

  bounded_deque_table #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (DATA_W)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the deque
  logic [DATA_W-1:0] list_mem [CAPACITY];
  int                list_head;
  int                list_count;

  deque_result_t pending_results [$];
  plan_row_t     plan_rows [$];

  // typed expectation riding along with the offered transaction
  bit            cur_typed = 1'b0;
  deque_result_t cur_want  = '0;

  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  bit  long_hold_req = 1'b0;
  int  errors = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_overflow = 0;
  int  n_underflow = 0;
  int  n_range = 0;
  int  n_full_hits = 0;

  deque_result_t predicted;
  deque_result_t oldest_result;

  function automatic int ring_slot(input int off);
    return (list_head + off) % CAPACITY;
  endfunction

  function automatic deque_result_t deque_apply(input logic [ACT_W-1:0] act,
                                                input logic [POS_W-1:0] pos,
                                                input logic [DATA_W-1:0] elem);
    deque_result_t r;
    bit full;
    bit empty;
    r.element = '0;
    r.status  = ST_OK;
    full  = (list_count >= CAPACITY);
    empty = (list_count == 0);
    case (act)
      ACT_INS_HEAD: begin
        if (full) r.status = ST_OVERFLOW;
        else begin
          list_head = (list_head == 0) ? CAPACITY - 1 : list_head - 1;
          list_mem[list_head] = elem;
          list_count++;
        end
      end
      ACT_INS_TAIL: begin
        if (full) r.status = ST_OVERFLOW;
        else begin
          list_mem[ring_slot(list_count)] = elem;
          list_count++;
        end
      end
      ACT_REM_HEAD: begin
        if (empty) r.status = ST_UNDERFLOW;
        else begin
          list_head = ring_slot(1);
          list_count--;
        end
      end
      ACT_REM_TAIL: begin
        if (empty) r.status = ST_UNDERFLOW;
        else list_count--;
      end
      ACT_RD_HEAD: begin
        if (empty) r.status = ST_UNDERFLOW;
        else r.element = list_mem[list_head];
      end
      ACT_RD_TAIL: begin
        if (empty) r.status = ST_UNDERFLOW;
        else r.element = list_mem[ring_slot(list_count - 1)];
      end
      ACT_RD_INDEX: begin
        if (int'(pos) >= CAPACITY) r.status = ST_RANGE;
        else if (int'(pos) < list_count) r.element = list_mem[ring_slot(int'(pos))];
      end
      default: ;
    endcase
    r.count = list_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic void add_row(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                                  input logic [DATA_W-1:0] elem, input int reps,
                                  input bit typed, input logic [DATA_W-1:0] w_elem,
                                  input status_t w_status, input logic [CNT_W-1:0] w_count);
    plan_row_t row;
    row.act          = act;
    row.pos          = pos;
    row.elem         = elem;
    row.reps         = reps;
    row.typed        = typed;
    row.want.element = w_elem;
    row.want.status  = w_status;
    row.want.count   = w_count;
    plan_rows.push_back(row);
  endfunction

  // request side: prediction at the accepting edge
  always @(posedge clk) begin
    if (!rst && req_if.valid && req_if.ready) begin
      predicted = deque_apply(req_if.action, req_if.position, req_if.element_in);
      pending_results.push_back(cur_typed ? cur_want : predicted);
      n_accepted++;
      if (list_count == CAPACITY) n_full_hits++;
    end
  end

  // response side: compare against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: element_out %h status %0d count %0d",
               rsp_if.element_out, rsp_if.status, rsp_if.count);
        errors++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp_if.element_out !== oldest_result.element) begin
          $error("element_out mismatch: expected %h, actual %h",
                 oldest_result.element, rsp_if.element_out);
          errors++;
        end
        if (rsp_if.status !== oldest_result.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 oldest_result.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.count !== oldest_result.count) begin
          $error("count mismatch: expected %0d, actual %0d",
                 oldest_result.count, rsp_if.count);
          errors++;
        end
        n_checked++;
        case (oldest_result.status)
          ST_OVERFLOW:  n_overflow++;
          ST_UNDERFLOW: n_underflow++;
          ST_RANGE:     n_range++;
          default: ;
        endcase
      end
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
      end
      rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic offer(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                       input logic [DATA_W-1:0] elem, input bit typed,
                       input deque_result_t want);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.position   <= pos;
    req_if.element_in <= elem;
    cur_typed         <= typed;
    cur_want          <= want;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic quiesce();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // segments bias the deque toward filling, draining or churning
  task automatic random_items(input int n, input int hold_at);
    int k;
    int seg;
    int mode;
    int w;
    int ins_pct;
    int rem_pct;
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    seg = 0;
    mode = 0;
    for (k = 0; k < n; k++) begin
      if (seg == 0) begin
        mode = $urandom_range(2);
        seg  = $urandom_range(150, 250);
      end
      seg--;
      if (k == hold_at) long_hold_req = 1'b1;
      case (mode)
        0:       begin ins_pct = 70; rem_pct = 15; end
        1:       begin ins_pct = 15; rem_pct = 70; end
        default: begin ins_pct = 30; rem_pct = 30; end
      endcase
      w = $urandom_range(99);
      if (w < ins_pct)
        act = $urandom_range(1) ? ACT_INS_TAIL : ACT_INS_HEAD;
      else if (w < ins_pct + rem_pct)
        act = $urandom_range(1) ? ACT_REM_TAIL : ACT_REM_HEAD;
      else if (w < 98) begin
        case ($urandom_range(3))
          0:       act = ACT_RD_HEAD;
          1:       act = ACT_RD_TAIL;
          default: act = ACT_RD_INDEX;
        endcase
      end else
        act = ACT_UNUSED;
      pos = POS_W'($urandom_range(127));
      if (act == ACT_RD_INDEX) begin
        w = $urandom_range(9);
        if (w < 6 && list_count > 0) pos = POS_W'($urandom_range(list_count - 1));
        else if (w >= 8) pos = POS_W'($urandom_range(127, CAPACITY));
      end
      offer(act, pos, $urandom, 1'b0, '0);
    end
  endtask

  initial begin
    int i;
    req_if.valid      = 1'b0;
    req_if.action     = ACT_INS_HEAD;
    req_if.position   = '0;
    req_if.element_in = '0;
    list_head  = 0;
    list_count = 0;

    // empty deque: every head or tail read and remove underflows, index reads range-check
    add_row(ACT_RD_HEAD,  7'd0,   32'hA5A5_5A5A, 1, 1, '0, ST_UNDERFLOW, 7'd0);
    add_row(ACT_RD_TAIL,  7'd127, 32'h0000_0000, 1, 1, '0, ST_UNDERFLOW, 7'd0);
    add_row(ACT_REM_HEAD, 7'd64,  32'hFFFF_FFFF, 1, 1, '0, ST_UNDERFLOW, 7'd0);
    add_row(ACT_REM_TAIL, 7'd1,   32'h5A5A_A5A5, 1, 1, '0, ST_UNDERFLOW, 7'd0);
    add_row(ACT_RD_INDEX, 7'd0,   32'h0000_0000, 1, 1, '0, ST_OK,        7'd0);
    add_row(ACT_RD_INDEX, 7'd127, 32'hFFFF_FFFF, 1, 1, '0, ST_RANGE,     7'd0);
    add_row(ACT_RD_INDEX, 7'd64,  32'h0000_0000, 1, 1, '0, ST_RANGE,     7'd0);
    add_row(ACT_UNUSED,   7'd85,  32'hFFFF_FFFF, 1, 1, '0, ST_OK,        7'd0);
    // two elements at the word extremes
    add_row(ACT_INS_TAIL, 7'd127, 32'hFFFF_FFFF, 1, 1, '0, ST_OK, 7'd1);
    add_row(ACT_INS_HEAD, 7'd0,   32'h0000_0000, 1, 1, '0, ST_OK, 7'd2);
    add_row(ACT_RD_HEAD,  7'd42,  32'h1234_5678, 1, 1, '0, ST_OK, 7'd2);
    add_row(ACT_RD_TAIL,  7'd0,   32'h0000_0000, 1, 1, 32'hFFFF_FFFF, ST_OK, 7'd2);
    add_row(ACT_RD_INDEX, 7'd1,   32'h0000_0000, 1, 1, 32'hFFFF_FFFF, ST_OK, 7'd2);
    // positions past the count but below capacity read zero
    add_row(ACT_RD_INDEX, 7'd2,   32'hFFFF_FFFF, 1, 1, '0, ST_OK, 7'd2);
    add_row(ACT_RD_INDEX, 7'd63,  32'hFFFF_FFFF, 1, 1, '0, ST_OK, 7'd2);
    // fill through the head up to capacity, with the ring pointer already wrapped below zero
    add_row(ACT_INS_HEAD, 7'd0,   32'h8000_0001, CAPACITY - 2, 0, '0, ST_OK, '0);
    add_row(ACT_INS_HEAD, 7'd0,   32'hDEAD_BEEF, 1, 1, '0, ST_OVERFLOW, 7'd64);
    add_row(ACT_INS_TAIL, 7'd127, 32'hFFFF_FFFF, 1, 1, '0, ST_OVERFLOW, 7'd64);
    add_row(ACT_RD_INDEX, 7'd63,  32'h0000_0000, 1, 1, 32'hFFFF_FFFF, ST_OK, 7'd64);
    add_row(ACT_UNUSED,   7'd127, 32'hFFFF_FFFF, 1, 1, '0, ST_OK, 7'd64);
    add_row(ACT_REM_TAIL, 7'd0,   32'h0000_0000, 1, 1, '0, ST_OK, 7'd63);
    add_row(ACT_RD_TAIL,  7'd0,   32'h0000_0000, 1, 0, '0, ST_OK, '0);
    add_row(ACT_REM_HEAD, 7'd127, 32'hFFFF_FFFF, CAPACITY - 1, 0, '0, ST_OK, '0);
    add_row(ACT_INS_TAIL, 7'd0,   32'h7FFF_FFFE, 5, 0, '0, ST_OK, '0);
    add_row(ACT_RD_INDEX, 7'd4,   32'h0000_0000, 1, 0, '0, ST_OK, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    snd_idle_pct = 10;
    rcv_idle_pct = 58;
    foreach (plan_rows[r]) begin
      for (i = 0; i < plan_rows[r].reps; i++)
        offer(plan_rows[r].act, plan_rows[r].pos, plan_rows[r].elem + i,
              plan_rows[r].typed, plan_rows[r].want);
    end
    random_items(430, 200);
    quiesce();

    snd_idle_pct = 58;
    rcv_idle_pct = 10;
    random_items(430, -1);
    quiesce();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_items(440, -1);
    quiesce();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d transactions, %0d results checked, deque full after %0d of them",
             n_accepted, n_checked, n_full_hits);
    $display("error statuses seen: %0d overflow, %0d underflow, %0d out of range",
             n_overflow, n_underflow, n_range);
    if (errors == 0)
      $display("PASS bounded_deque_table");
    else
      $display("FAIL bounded_deque_table");
    $finish;
  end

  initial begin
    #(12 * 300000);
    $error("timeout with %0d results still pending", pending_results.size());
    $display("FAIL bounded_deque_table");
    $finish;
  end

endmodule
